// ===== rtl/dlp_pkg.sv =====
// dlp_pkg: shared types and constants of the decimal list parser
// character classes, parser phases, register indexes, result and config records
// no dependencies
package dlp_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_ZERO  = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    localparam logic [15:0] RST_MIN_COUNT = 16'd0;
    localparam logic [15:0] RST_MAX_COUNT = 16'hFFFF;
    localparam logic [31:0] RST_MIN_VALUE = 32'd0;
    localparam logic [31:0] RST_MAX_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_SPACE,
        CL_SEP,
        CL_ZERO,
        CL_OTHER
    } t_ch_class;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NUM   = 2'd1,
        PH_AFTER = 2'd2,
        PH_SEP   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REG_MIN_COUNT = 2'd0,
        REG_MAX_COUNT = 2'd1,
        REG_MIN_VALUE = 2'd2,
        REG_MAX_VALUE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_ch_class  cls;
        logic [3:0] digit;
    } t_token;

    typedef struct packed {
        logic [15:0] min_count;
        logic [15:0] max_count;
        logic [31:0] min_value;
        logic [31:0] max_value;
    } t_cfg;

    typedef struct packed {
        logic [31:0] value;
        logic        value_valid;
        logic [15:0] index;
        logic        done_res;
        logic        fail;
        logic [15:0] total;
    } t_result;

endpackage

// ===== rtl/decimal_list_parser.sv =====
// decimal_list_parser: top level with register port, front, queue and back
// depends on dlp_pkg, dlp_front, dlp_queue, dlp_back
//
// usage:
//   input channel: one character per item on i_ch, handshake i_in_valid and
//   o_in_stall; output channel: o_out_valid and i_out_stall with the result
//   fields o_value, o_value_valid, o_index, o_done_res, o_fail, o_total.
//   a zero character ends a list and gives a done item with the count and
//   the fail flag; digits ended by space or separator give a value item.
//   registers min_count, max_count, min_value, max_value sit at byte
//   addresses 0, 4, 8, 12 of the apb port; pready is always high.
// timing:
//   an accepted character is queued and any result registered once the back
//   part pops it; one character per cycle is sustained while i_out_stall is
//   low; the digit loop's multiply-by-ten, add and compare are combinational.
// reset:
//   synchronous, active low; registers return to their reset values, the
//   queue empties and the parser returns to the start of a list.
// stall:
//   while the receiver stalls, the result holds; the queue keeps taking
//   characters until it is full, then o_in_stall rises.
module decimal_list_parser import dlp_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_value_valid,
    output logic [15:0] o_index,
    output logic        o_done_res,
    output logic        o_fail,
    output logic [15:0] o_total
);

    t_cfg    r_cfg;
    t_reg_idx reg_idx;
    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_token  tok_in;
    t_token  tok_out;
    t_result res;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count <= RST_MIN_COUNT;
            r_cfg.max_count <= RST_MAX_COUNT;
            r_cfg.min_value <= RST_MIN_VALUE;
            r_cfg.max_value <= RST_MAX_VALUE;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MIN_COUNT: r_cfg.min_count <= pwdata[15:0];
                REG_MAX_COUNT: r_cfg.max_count <= pwdata[15:0];
                REG_MIN_VALUE: r_cfg.min_value <= pwdata;
                REG_MAX_VALUE: r_cfg.max_value <= pwdata;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_COUNT: prdata = 32'(r_cfg.min_count);
            REG_MAX_COUNT: prdata = 32'(r_cfg.max_count);
            REG_MIN_VALUE: prdata = r_cfg.min_value;
            REG_MAX_VALUE: prdata = r_cfg.max_value;
            default:       prdata = '0;
        endcase
    end

    dlp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_ch       (i_ch),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_token    (tok_in)
    );

    dlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (tok_in),
        .i_pop   (pop),
        .o_token (tok_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dlp_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_token     (tok_out),
        .i_q_empty   (q_empty),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_value       = res.value;
    assign o_value_valid = res.value_valid;
    assign o_index       = res.index;
    assign o_done_res    = res.done_res;
    assign o_fail        = res.fail;
    assign o_total       = res.total;

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("token popped from empty queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_value_item_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_value_valid && !o_fail && o_total == 16'd0))
        else $error("value item carries done fields");

    a_fail_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fail) |-> o_done_res)
        else $error("fail flag outside a done item");
`endif

endmodule

// ===== rtl/dlp_front.sv =====
// dlp_front: accepts characters and classifies them into tokens
// depends on dlp_pkg
module dlp_front import dlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_ch,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_token     o_token
);

    t_token tok;

    always_comb begin
        tok.digit = 4'(i_ch - CH_DIG0);
        if (i_ch == CH_ZERO) begin
            tok.cls = CL_ZERO;
        end else if (i_ch >= CH_DIG0 && i_ch <= CH_DIG9) begin
            tok.cls = CL_DIGIT;
        end else if (i_ch == CH_SPACE || (i_ch >= CH_TAB && i_ch <= CH_CR)) begin
            tok.cls = CL_SPACE;
        end else if (i_ch == CH_COMMA || i_ch == CH_SEMI) begin
            tok.cls = CL_SEP;
        end else begin
            tok.cls = CL_OTHER;
        end
    end

    // hold off the sender while reset is applied
    logic r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full || !r_live;
    assign o_push     = i_in_valid && !o_in_stall;
    assign o_token    = tok;

endmodule

// ===== rtl/dlp_queue.sv =====
// dlp_queue: short token queue between front and back
// depends on dlp_pkg
module dlp_queue import dlp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output t_token o_token,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    assign o_token = r_mem[r_rd];
    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);

endmodule

// ===== rtl/dlp_back.sv =====
// dlp_back: list parsing state machine and output register
// depends on dlp_pkg
module dlp_back import dlp_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_token  i_token,
    input  logic    i_q_empty,
    input  logic    i_out_stall,
    output logic    o_pop,
    output logic    o_out_valid,
    output t_result o_res
);

    localparam int AW = VALUE_BITS + 4;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [31:0]   VMASK = 32'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [CW-1:0] CMASK = CW'((64'd1 << COUNT_BITS) - 64'd1);

    t_phase                r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_err, n_err;
    logic                  r_out_valid;
    t_result               r_res;

    logic [31:0]           lim32;
    logic [AW-1:0]         vlimit;
    logic [CW-1:0]         climit;
    logic [AW-1:0]         acc_w;
    logic [AW-1:0]         prod;
    logic [AW-1:0]         dig_w;
    logic                  below_min;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  emit;
    t_result               res;
    logic                  fail;

    always_comb begin
        lim32  = (i_cfg.max_value > VMASK) ? VMASK : i_cfg.max_value;
        vlimit = AW'(lim32[VALUE_BITS-1:0]);
        climit = (CW'(i_cfg.max_count) > CMASK) ? CMASK : CW'(i_cfg.max_count);
        acc_w  = AW'(r_acc);
        dig_w  = AW'(i_token.digit);
        prod   = (acc_w << 3) + (acc_w << 1) + dig_w;
        below_min = 32'(r_acc) < i_cfg.min_value;
        cnt_inc   = r_cnt + 1'b1;
    end

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_err   = r_err;
        emit    = 1'b0;
        fail    = 1'b0;
        res     = '0;
        if (o_pop) begin
            if (i_token.cls == CL_ZERO) begin
                fail = r_err;
                if (!r_err && r_phase == PH_NUM) begin
                    if (below_min) begin
                        fail = 1'b1;
                    end else begin
                        res.value       = 32'(r_acc);
                        res.value_valid = 1'b1;
                        res.index       = 16'(r_cnt);
                        n_cnt           = cnt_inc;
                    end
                end else if (!r_err && r_phase == PH_SEP) begin
                    fail = 1'b1;
                end
                if (!fail && CW'(n_cnt) < CW'(i_cfg.min_count)) begin
                    fail = 1'b1;
                end
                emit         = 1'b1;
                res.done_res = 1'b1;
                res.fail     = fail;
                res.total    = 16'(n_cnt);
                // list over: back to the start for the next one
                n_phase = PH_START;
                n_acc   = '0;
                n_cnt   = '0;
                n_err   = 1'b0;
            end else if (!r_err) begin
                case (r_phase)
                    PH_NUM: begin
                        case (i_token.cls)
                            CL_DIGIT: begin
                                n_acc = prod[VALUE_BITS-1:0];
                                if (prod > vlimit) begin
                                    n_err = 1'b1;
                                end
                            end
                            CL_SPACE, CL_SEP: begin
                                if (below_min) begin
                                    n_err = 1'b1;
                                end else begin
                                    emit            = 1'b1;
                                    res.value       = 32'(r_acc);
                                    res.value_valid = 1'b1;
                                    res.index       = 16'(r_cnt);
                                    n_cnt           = cnt_inc;
                                    n_phase = (i_token.cls == CL_SEP) ? PH_SEP : PH_AFTER;
                                end
                            end
                            default: n_err = 1'b1;
                        endcase
                    end
                    PH_AFTER: begin
                        case (i_token.cls)
                            CL_SEP:   n_phase = PH_SEP;
                            CL_SPACE: n_phase = PH_AFTER;
                            default:  n_err = 1'b1;
                        endcase
                    end
                    default: begin
                        // start of list or after a separator: a number must begin
                        case (i_token.cls)
                            CL_DIGIT: begin
                                if (CW'(r_cnt) >= climit || dig_w > vlimit) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_acc   = VALUE_BITS'(i_token.digit);
                                    n_phase = PH_NUM;
                                end
                            end
                            CL_SPACE: n_phase = r_phase;
                            default:  n_err = 1'b1;
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench of the decimal list parser
// streams well-formed and broken lists under random burst and stall patterns, predicts results
// depends on dlp_pkg and decimal_list_parser
`timescale 1ns / 100ps

module tb_top;
    import dlp_pkg::*;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_ch;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_value;
    logic        o_value_valid;
    logic [15:0] o_index;
    logic        o_done_res;
    logic        o_fail;
    logic [15:0] o_total;

    decimal_list_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_value_valid(o_value_valid),
        .o_index      (o_index),
        .o_done_res   (o_done_res),
        .o_fail       (o_fail),
        .o_total      (o_total)
    );

    // parser copy kept by the testbench
    logic [15:0] cfg_min_count;
    logic [15:0] cfg_max_count;
    logic [31:0] cfg_min_value;
    logic [31:0] cfg_max_value;
    t_phase      parse_state;
    logic [63:0] accum;
    logic [15:0] list_count;
    bit          list_error;

    logic [7:0] chars_to_send[$];
    logic [7:0] list_bytes[$];
    t_result    parse_results_due[$];

    int       failures;
    int       chars_taken;
    bit       char_taken;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    int       long_holds;
    int       mode_left;
    int       stall_tick;
    t_rx_mode rx_mode;
    int       idle_cycles;

    function automatic bit is_digit_char(input logic [7:0] c);
        return c >= CH_DIG0 && c <= CH_DIG9;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        return c == CH_COMMA || c == CH_SEMI;
    endfunction

    task automatic clear_list_state();
        parse_state = PH_START;
        accum = '0;
        list_count = '0;
        list_error = 1'b0;
    endtask

    // works out the result of one accepted character, if any
    task automatic parse_char(input logic [7:0] c);
        t_result r;
        bit      bad;
        bit      emit;
        r = '0;
        emit = 1'b0;
        if (c == CH_ZERO) begin
            bad = list_error;
            if (!bad && parse_state == PH_NUM) begin
                if (accum < {32'd0, cfg_min_value}) begin
                    bad = 1'b1;
                end else begin
                    r.value = accum[31:0];
                    r.value_valid = 1'b1;
                    r.index = list_count;
                    list_count = list_count + 16'd1;
                end
            end else if (!bad && parse_state == PH_SEP) begin
                bad = 1'b1;
            end
            if (!bad && list_count < cfg_min_count) bad = 1'b1;
            r.done_res = 1'b1;
            r.fail = bad;
            r.total = list_count;
            emit = 1'b1;
            clear_list_state();
        end else if (!list_error) begin
            case (parse_state)
                PH_NUM: begin
                    if (is_digit_char(c)) begin
                        accum = accum * 10 + 64'(c - CH_DIG0);
                        if (accum > {32'd0, cfg_max_value}) list_error = 1'b1;
                    end else if (is_blank(c) || is_separator(c)) begin
                        if (accum < {32'd0, cfg_min_value}) begin
                            list_error = 1'b1;
                        end else begin
                            r.value = accum[31:0];
                            r.value_valid = 1'b1;
                            r.index = list_count;
                            list_count = list_count + 16'd1;
                            parse_state = is_separator(c) ? PH_SEP : PH_AFTER;
                            emit = 1'b1;
                        end
                    end else begin
                        list_error = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (is_separator(c)) parse_state = PH_SEP;
                    else if (!is_blank(c)) list_error = 1'b1;
                end
                default: begin
                    if (is_digit_char(c)) begin
                        if (list_count >= cfg_max_count ||
                                {24'd0, c - CH_DIG0} > cfg_max_value) begin
                            list_error = 1'b1;
                        end else begin
                            accum = 64'(c - CH_DIG0);
                            parse_state = PH_NUM;
                        end
                    end else if (!is_blank(c)) begin
                        list_error = 1'b1;
                    end
                end
            endcase
        end
        if (emit) parse_results_due.push_back(r);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_COUNT: cfg_min_count = data[15:0];
            REG_MAX_COUNT: cfg_max_count = data[15:0];
            REG_MIN_VALUE: cfg_min_value = data;
            default:       cfg_max_value = data;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] min_cnt, input logic [15:0] max_cnt,
                              input logic [31:0] min_val, input logic [31:0] max_val);
        write_reg(REG_MIN_COUNT, {16'd0, min_cnt});
        write_reg(REG_MAX_COUNT, {16'd0, max_cnt});
        write_reg(REG_MIN_VALUE, min_val);
        write_reg(REG_MAX_VALUE, max_val);
    endtask

    // sender holds off here until every expected result is back
    task automatic wait_idle();
        while (chars_to_send.size() != 0 || parse_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) chars_to_send.push_back(8'(s[i]));
        chars_to_send.push_back(CH_ZERO);
    endtask

    task automatic add_blanks();
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n) begin
            if ($urandom_range(0, 2) == 0) list_bytes.push_back(CH_SPACE);
            else list_bytes.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        end
    endtask

    task automatic add_number(input logic [63:0] v);
        logic [7:0] digits[$];
        int         zeros;
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
        repeat (zeros) list_bytes.push_back(CH_DIG0);
        do begin
            digits.push_front(CH_DIG0 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) list_bytes.push_back(digits[i]);
    endtask

    // values cluster around the configured bounds
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 64'($urandom_range(0, 99));
            3:       return {32'd0, cfg_min_value};
            4:       return (cfg_min_value == 0) ? 64'd0 : {32'd0, cfg_min_value} - 1;
            5:       return {32'd0, cfg_max_value};
            6:       return {32'd0, cfg_max_value} + 1;
            7:       return 64'($urandom);
            default: return 64'($urandom_range(0, 9));
        endcase
    endfunction

    // appends one list to the send queue, returns its length
    task automatic queue_list(output int len);
        int n;
        int kind;
        list_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // pure noise, may include an early terminator
            repeat ($urandom_range(1, 8)) list_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            add_blanks();
            for (int i = 0; i < n; i++) begin
                if (i > 0) begin
                    add_blanks();
                    list_bytes.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
                    add_blanks();
                end
                add_number(pick_value());
            end
            if ($urandom_range(0, 1) == 0) add_blanks();
            if (kind <= 4) begin
                case ($urandom_range(0, 2))
                    0: list_bytes.insert($urandom_range(0, list_bytes.size()),
                                         8'($urandom_range(1, 255)));
                    1: list_bytes.push_back(CH_COMMA);
                    default: list_bytes.insert($urandom_range(0, list_bytes.size()),
                                               CH_SEMI);
                endcase
            end
        end
        foreach (list_bytes[i]) chars_to_send.push_back(list_bytes[i]);
        chars_to_send.push_back(CH_ZERO);
        len = list_bytes.size() + 1;
    endtask

    task automatic random_limits();
        logic [15:0] min_cnt;
        logic [15:0] max_cnt;
        logic [31:0] min_val;
        logic [31:0] max_val;
        min_cnt = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 4)) : 16'd0;
        max_cnt = $urandom_range(0, 1) ? 16'($urandom_range(0, 6)) : 16'hFFFF;
        min_val = $urandom_range(0, 1) ? 32'($urandom_range(1, 200)) : 32'd0;
        case ($urandom_range(0, 3))
            0:       max_val = min_val + 32'($urandom_range(0, 1000));
            1:       max_val = 32'd65535;
            2:       max_val = 32'hFFFF_FFFF;
            default: max_val = $urandom;
        endcase
        set_limits(min_cnt, max_cnt, min_val, max_val);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input side: record acceptance and predict
    always @(posedge i_clk) begin
        char_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (char_taken) begin
            parse_char(i_ch);
            void'(chars_to_send.pop_front());
            chars_taken++;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || char_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (chars_to_send.size() != 0) begin
                i_in_valid <= 1'b1;
                i_ch <= chars_to_send[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall modes plus two long hold-offs
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (long_holds < 2 && chars_taken >= 400 + 800 * long_holds) begin
            long_holds++;
            hold_left = LONG_HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 4) < 3);
                default:  i_out_stall <= ((stall_tick % 7) < 2);
            endcase
        end
        stall_tick++;
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // output side: compare with the oldest expected result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (parse_results_due.size() == 0) begin
                $error("result item with none expected: value %0d index %0d done %0b",
                       o_value, o_index, o_done_res);
                failures++;
            end else begin
                want = parse_results_due.pop_front();
                report_field("value", want.value, o_value);
                report_field("value_valid", 32'(want.value_valid), 32'(o_value_valid));
                report_field("index", 32'(want.index), 32'(o_index));
                report_field("done_res", 32'(want.done_res), 32'(o_done_res));
                report_field("fail", 32'(want.fail), 32'(o_fail));
                report_field("total", 32'(want.total), 32'(o_total));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int phase_chars;
        int len;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_ch = '0;
        i_out_stall = 1'b0;
        failures = 0;
        chars_taken = 0;
        char_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        long_holds = 0;
        mode_left = 0;
        stall_tick = 0;
        rx_mode = RX_FREE;
        idle_cycles = 0;
        cfg_min_count = RST_MIN_COUNT;
        cfg_max_count = RST_MAX_COUNT;
        cfg_min_value = RST_MIN_VALUE;
        cfg_max_value = RST_MAX_VALUE;
        clear_list_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: largest value, zero, both separators, blanks, number at terminator,
        // leading separator, digit after blank inside a number
        push_text("4294967295,0 ;\t7");
        push_text(",");
        push_text("1 2");
        wait_idle();

        // opposite extremes: every list fails
        set_limits(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'd0);
        push_text("");
        push_text("5");
        push_text("0 ");
        wait_idle();

        set_limits(16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
        for (int ph = 0; ph < 7; ph++) begin
            if (ph != 0) random_limits();
            phase_chars = 0;
            while (phase_chars < 230) begin
                queue_list(len);
                phase_chars += len;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== decimal_list_parser.f =====
rtl/dlp_pkg.sv
rtl/dlp_front.sv
rtl/dlp_queue.sv
rtl/dlp_back.sv
rtl/decimal_list_parser.sv
dv/tb_top.sv
